/* hw/rtl/bbct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bbct_pkg;

    localparam int BUFFERS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int DEVICE_W = 16;
    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;
    localparam int TAG_W    = DEVICE_W + SECTOR_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_FILL    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_WAIT    = 2'd1,
        ST_NOBUF   = 2'd2,
        ST_NOTBUSY = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   granted_slot;
        logic                needs_fill;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rd_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hw/rtl/bbct_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bbct_req_if
    import bbct_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DEVICE_W-1:0] device;
    logic [SECTOR_W-1:0] sector;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output opcode, output device, output sector,
                    output slot, input ready);
    modport sink   (input valid, input opcode, input device, input sector,
                    input slot, output ready);
endinterface

interface bbct_rsp_if
    import bbct_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                needs_fill;

    modport source (output valid, output status, output granted_slot,
                    output needs_fill, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input needs_fill, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bbct_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbct_ctrl
    import bbct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last tag compare lands here
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_load_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN))
        else $error("load did not start a scan");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.rd_last) |=> (r_state == S_DRAIN))
        else $error("scan did not stop after the last entry");

    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (!o_cmd.commit && r_state == S_IDLE))
        else $error("commit not followed by idle");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bbct_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbct_dpath
    import bbct_pkg::*;
#(
    parameter int BUFFERS = BUFFERS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [DEVICE_W-1:0] i_device,
    input  wire logic [SECTOR_W-1:0] i_sector,
    input  wire logic [SLOT_W-1:0]   i_slot,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_rsp                     o_rsp
);

    localparam int IDX_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;

    // latched request
    t_opcode             r_op;
    logic [DEVICE_W-1:0] r_dev;
    logic [SECTOR_W-1:0] r_sec;
    logic [SLOT_W-1:0]   r_slot;

    // tag store and per-entry marks
    logic [TAG_W-1:0]    r_tag_mem [BUFFERS];
    logic [BUFFERS-1:0]  r_tag_vld;
    logic [BUFFERS-1:0]  r_busy;
    logic [BUFFERS-1:0]  r_full;
    logic [BUFFERS-1:0]  n_tag_vld;
    logic [BUFFERS-1:0]  n_busy;
    logic [BUFFERS-1:0]  n_full;

    // scan
    logic [IDX_W-1:0]    r_rd_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_en;
    logic [TAG_W-1:0]    r_rd_data;
    logic                r_rd_tv;
    logic                r_hit_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_spare_found;
    logic [IDX_W-1:0]    r_spare_idx;

    logic                r_out_vld;
    t_rsp                r_out;

    logic [TAG_W-1:0]    w_key;
    logic                w_match;
    logic [IDX_W-1:0]    w_slot_idx;
    logic                w_slot_ok;
    logic                w_we;
    t_rsp                w_res;

    assign w_key      = {r_dev, r_sec};
    // an entry never written still carries the all-zero reset tag
    assign w_match    = r_rd_tv ? (r_rd_data == w_key) : (w_key == '0);
    assign w_slot_idx = IDX_W'(r_slot);
    assign w_slot_ok  = (int'(r_slot) < BUFFERS);

    assign o_sts.rd_last  = (r_rd_idx == IDX_W'(BUFFERS - 1));
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_rsp          = r_out;

    always_comb begin
        n_tag_vld = r_tag_vld;
        n_busy    = r_busy;
        n_full    = r_full;
        w_we      = 1'b0;
        w_res     = '{status: ST_DONE, granted_slot: '0, needs_fill: 1'b0};
        if (i_cmd.commit) begin
            unique case (r_op)
                OP_ACQUIRE: begin
                    if (r_hit_found) begin
                        if (r_busy[r_hit_idx]) begin
                            w_res.status = ST_WAIT;
                        end else begin
                            n_busy[r_hit_idx]  = 1'b1;
                            w_res.granted_slot = SLOT_W'(r_hit_idx);
                            w_res.needs_fill   = !r_full[r_hit_idx];
                        end
                    end else if (!r_spare_found) begin
                        w_res.status = ST_NOBUF;
                    end else begin
                        w_we                   = 1'b1;
                        n_tag_vld[r_spare_idx] = 1'b1;
                        n_busy[r_spare_idx]    = 1'b1;
                        n_full[r_spare_idx]    = 1'b0;
                        w_res.granted_slot     = SLOT_W'(r_spare_idx);
                        w_res.needs_fill       = 1'b1;
                    end
                end
                OP_FILL: begin
                    if (w_slot_ok) begin
                        n_full[w_slot_idx] = 1'b1;
                    end else begin
                        w_res.status = ST_NOTBUSY;
                    end
                end
                OP_RELEASE: begin
                    if (w_slot_ok && r_busy[w_slot_idx]) begin
                        n_busy[w_slot_idx] = 1'b0;
                    end else begin
                        w_res.status = ST_NOTBUSY;
                    end
                end
                OP_NOP: begin
                    w_res.status = ST_DONE;
                end
                default: begin
                    w_res.status = ST_DONE;
                end
            endcase
        end
    end

    // tag memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tag_mem[r_spare_idx] <= w_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_tag_mem[r_rd_idx];
            r_rd_tv   <= r_tag_vld[r_rd_idx];
            r_cmp_idx <= r_rd_idx;
        end
    end

    // payload registers, scan index, hit and spare indices, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_opcode'(i_opcode);
            r_dev  <= i_device;
            r_sec  <= i_sector;
            r_slot <= i_slot;
        end
        if (i_cmd.load) begin
            r_rd_idx <= '0;
        end else if (i_cmd.issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (r_cmp_en && !r_hit_found && w_match) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp_en && !r_spare_found && !r_busy[r_cmp_idx]) begin
            r_spare_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld     <= '0;
            r_busy        <= '0;
            r_full        <= '0;
            r_cmp_en      <= 1'b0;
            r_hit_found   <= 1'b0;
            r_spare_found <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_tag_vld <= n_tag_vld;
            r_busy    <= n_busy;
            r_full    <= n_full;
            r_cmp_en  <= i_cmd.issue;
            if (i_cmd.load) begin
                r_hit_found   <= 1'b0;
                r_spare_found <= 1'b0;
            end else if (r_cmp_en) begin
                // lowest matching and lowest free entries win
                r_hit_found   <= r_hit_found || w_match;
                r_spare_found <= r_spare_found || !r_busy[r_cmp_idx];
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_marks_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> (r_busy == $past(r_busy) && r_full == $past(r_full)))
        else $error("busy or full mark changed outside a commit");

    a_grant_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_ACQUIRE && w_res.status == ST_DONE)
            |=> r_busy[$past(r_hit_found) ? $past(r_hit_idx) : $past(r_spare_idx)])
        else $error("granted entry not marked busy");

    a_commit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("result register not loaded on commit");
`endif

endmodule

`default_nettype wire

/* hw/rtl/block_buffer_cache_tags_top.sv */
// block buffer cache tag table
// request channel i_req carries opcode, device, sector and slot; acquire looks up
// (device, sector), mark filled sets an entry's full mark, release clears busy
// response channel o_rsp carries one word per request: status, granted_slot and
// needs_fill
// each request walks the whole tag memory, one entry per cycle through its single
// read port, to find the lowest matching entry and the lowest free one together
// the request word is latched, the scan reads every entry, a drain state lets the last
// compare land, and the commit state writes the response register once it is free;
// the next request is taken only after that commit, when the block is idle again
// a finished response sits in an output register, so a new request is taken
// while it waits; if the receiver stalls long enough that a second response is
// ready, the block holds it and takes no further request until the first leaves
// reset is synchronous and active low; it empties the table at once (every entry
// reads as device 0, sector 0, not busy, not full) and drops any pending word
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_tags_top
    import bbct_pkg::*;
#(
    parameter int BUFFERS = BUFFERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bbct_req_if.sink   i_req,
    bbct_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_rsp w_rsp;

    bbct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    bbct_dpath #(
        .BUFFERS (BUFFERS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_opcode    (i_req.opcode),
        .i_device    (i_req.device),
        .i_sector    (i_req.sector),
        .i_slot      (i_req.slot),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.status       = w_rsp.status;
    assign o_rsp.granted_slot = w_rsp.granted_slot;
    assign o_rsp.needs_fill   = w_rsp.needs_fill;

endmodule

`default_nettype wire

/* dv/bbct_checker.sv */
`timescale 1ns / 1ps

module bbct_checker
    import bbct_pkg::*;
#(
    parameter int BUFFERS = BUFFERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbct_req_if  i_req,
    bbct_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_answered,
    output int   o_waits,
    output int   o_nobufs,
    output int   o_notbusy
);

    logic [DEVICE_W-1:0] tag_dev  [BUFFERS];
    logic [SECTOR_W-1:0] tag_sec  [BUFFERS];
    logic                busy     [BUFFERS];
    logic                full     [BUFFERS];

    t_rsp slot_answers[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_answered   = 0;
        o_waits      = 0;
        o_nobufs     = 0;
        o_notbusy    = 0;
    end

    // one request against the shadow tag table, updating it as the block would
    function automatic t_rsp lookup_answer(t_opcode op, logic [DEVICE_W-1:0] dev,
                                           logic [SECTOR_W-1:0] sec,
                                           logic [SLOT_W-1:0] slot);
        t_rsp ans;
        int   hit;
        int   spare;
        ans = '{ST_DONE, '0, 1'b0};
        case (op)
            OP_ACQUIRE: begin
                hit   = -1;
                spare = -1;
                for (int k = 0; k < BUFFERS; k++) begin
                    if (hit < 0 && tag_dev[k] == dev && tag_sec[k] == sec)
                        hit = k;
                    if (spare < 0 && !busy[k])
                        spare = k;
                end
                if (hit >= 0) begin
                    if (busy[hit]) begin
                        ans.status = ST_WAIT;
                    end else begin
                        busy[hit]        = 1'b1;
                        ans.granted_slot = SLOT_W'(hit);
                        ans.needs_fill   = !full[hit];
                    end
                end else if (spare < 0) begin
                    ans.status = ST_NOBUF;
                end else begin
                    // miss: retag the lowest free entry
                    tag_dev[spare]   = dev;
                    tag_sec[spare]   = sec;
                    busy[spare]      = 1'b1;
                    full[spare]      = 1'b0;
                    ans.granted_slot = SLOT_W'(spare);
                    ans.needs_fill   = 1'b1;
                end
            end
            OP_FILL: begin
                if (int'(slot) >= BUFFERS)
                    ans.status = ST_NOTBUSY;
                else
                    full[slot] = 1'b1;
            end
            OP_RELEASE: begin
                if (int'(slot) >= BUFFERS || !busy[slot])
                    ans.status = ST_NOTBUSY;
                else
                    busy[slot] = 1'b0;
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic note_failure(input string msg);
        if (o_fail_count < 10)
            $display("%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int k = 0; k < BUFFERS; k++) begin
                tag_dev[k] = '0;
                tag_sec[k] = '0;
                busy[k]    = 1'b0;
                full[k]    = 1'b0;
            end
            slot_answers.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_answered++;
                case (t_status'(i_rsp.status))
                    ST_WAIT:    o_waits++;
                    ST_NOBUF:   o_nobufs++;
                    ST_NOTBUSY: o_notbusy++;
                    default: ;
                endcase
                if (slot_answers.size() == 0) begin
                    note_failure($sformatf("unexpected response word: status %0d slot %0d fill %0d",
                                           i_rsp.status, i_rsp.granted_slot, i_rsp.needs_fill));
                end else begin
                    want = slot_answers.pop_front();
                    if (i_rsp.status !== want.status
                            || i_rsp.granted_slot !== want.granted_slot
                            || i_rsp.needs_fill !== want.needs_fill)
                        note_failure($sformatf(
                            "response %0d: expected status %0d slot %0d fill %0d, got %0d %0d %0d",
                            o_answered, want.status, want.granted_slot, want.needs_fill,
                            i_rsp.status, i_rsp.granted_slot, i_rsp.needs_fill));
                end
            end
            if (i_req.valid && i_req.ready)
                slot_answers.push_back(lookup_answer(t_opcode'(i_req.opcode), i_req.device,
                                                     i_req.sector, i_req.slot));
        end
        o_pending = slot_answers.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bbct_pkg::*;

    localparam int BUFFERS      = BUFFERS_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * BUFFERS + 8;
    localparam int PHASE_WORDS  = 420;
    localparam int ROUND_WORDS  = 40;
    localparam int POOL         = 8;

    typedef enum {MODE_MIX, MODE_FLOOD, MODE_DRAIN} t_mode;

    logic i_clk;
    logic i_rst_n;

    bbct_req_if req_ch ();
    bbct_rsp_if rsp_ch ();

    int   fail_count;
    int   pending;
    int   answered;
    int   waits;
    int   nobufs;
    int   notbusy;
    int   words_sent    = 0;
    int   send_idle_pct = 15;
    int   rcvr_idle_pct = 68;
    logic rcvr_held     = 1'b0;
    event hold_rcvr;

    // small set of (device, sector) pairs so that acquires hit and collide
    logic [DEVICE_W-1:0] pool_dev [POOL];
    logic [SECTOR_W-1:0] pool_sec [POOL];

    block_buffer_cache_tags_top #(
        .BUFFERS (BUFFERS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bbct_checker #(
        .BUFFERS (BUFFERS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_answered   (answered),
        .o_waits      (waits),
        .o_nobufs     (nobufs),
        .o_notbusy    (notbusy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // long receiver stall, counted here
    initial begin
        forever begin
            @(hold_rcvr);
            rcvr_held = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            rcvr_held = 1'b0;
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = !rcvr_held && ($urandom_range(99) >= rcvr_idle_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input t_opcode op, input logic [DEVICE_W-1:0] dev,
                             input logic [SECTOR_W-1:0] sec, input logic [SLOT_W-1:0] slot);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, BUFFERS + 8)) @(negedge i_clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.opcode = op;
        req_ch.device = dev;
        req_ch.sector = sec;
        req_ch.slot   = slot;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic pick_pair(output logic [DEVICE_W-1:0] dev, output logic [SECTOR_W-1:0] sec);
        int idx;
        idx = $urandom_range(POOL - 1);
        dev = pool_dev[idx];
        sec = pool_sec[idx];
        // same device, neighbour's sector: a near miss
        if ($urandom_range(7) == 0)
            sec = pool_sec[(idx + 1) % POOL];
    endtask

    task automatic send_round(input t_mode mode, input int n);
        logic [DEVICE_W-1:0] dev;
        logic [SECTOR_W-1:0] sec;
        logic [SLOT_W-1:0]   slot;
        int                  r;
        int                  idx;
        for (int i = 0; i < n; i++) begin
            r    = $urandom_range(99);
            dev  = DEVICE_W'($urandom);
            sec  = $urandom;
            slot = SLOT_W'($urandom);
            case (mode)
                MODE_FLOOD: send_word(OP_ACQUIRE, dev, sec, slot);
                MODE_DRAIN: begin
                    if (r < 75)
                        send_word(OP_RELEASE, dev, sec, SLOT_W'(i));
                    else
                        send_word(OP_FILL, dev, sec, slot);
                end
                default: begin
                    if (r < 40) begin
                        pick_pair(dev, sec);
                        send_word(OP_ACQUIRE, dev, sec, slot);
                    end else if (r < 48) begin
                        send_word(OP_ACQUIRE, dev, sec, slot);
                    end else if (r < 68) begin
                        send_word(OP_FILL, dev, sec, slot);
                    end else if (r < 95) begin
                        send_word(OP_RELEASE, dev, sec, slot);
                    end else begin
                        send_word(OP_NOP, dev, sec, slot);
                    end
                end
            endcase
        end
        if ($urandom_range(3) == 0) begin
            idx           = $urandom_range(POOL - 1);
            pool_dev[idx] = DEVICE_W'($urandom);
            pool_sec[idx] = $urandom;
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle, input int n);
        int start;
        int r;
        send_idle_pct = sidle;
        rcvr_idle_pct = ridle;
        start         = words_sent;
        while (words_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 70)
                send_round(MODE_MIX, ROUND_WORDS);
            else if (r < 85)
                send_round(MODE_FLOOD, ROUND_WORDS);
            else
                send_round(MODE_DRAIN, ROUND_WORDS);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_NOP;
        req_ch.device = '0;
        req_ch.sector = '0;
        req_ch.slot   = '0;
        pool_dev[0]   = '0;
        pool_sec[0]   = '0;
        pool_dev[1]   = '1;
        pool_sec[1]   = '1;
        for (int k = 2; k < POOL; k++) begin
            pool_dev[k] = DEVICE_W'($urandom);
            pool_sec[k] = $urandom;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every entry comes out of reset tagged device 0, sector 0
        send_word(OP_ACQUIRE, '0, '0, '0);
        send_word(OP_ACQUIRE, '0, '0, '0);
        send_word(OP_FILL, '0, '0, '0);
        send_word(OP_RELEASE, '0, '0, '0);
        send_word(OP_ACQUIRE, '0, '0, '0);
        send_word(OP_RELEASE, '0, '0, '0);
        send_word(OP_RELEASE, '0, '0, '0);
        // fill of an idle entry still marks it full
        send_word(OP_FILL, '1, '1, '1);
        send_word(OP_ACQUIRE, '1, '1, '0);
        send_word(OP_ACQUIRE, '0, '0, '1);
        send_word(OP_ACQUIRE, '0, '1, '0);
        send_word(OP_ACQUIRE, '1, '0, '0);
        send_word(OP_RELEASE, '1, '1, '1);
        send_word(OP_NOP, '1, '1, '1);
        send_word(OP_ACQUIRE, '1, '1, '1);
        send_word(OP_RELEASE, '0, '0, '0);
        send_word(OP_ACQUIRE, '1, '1, '0);

        // run the table out of free entries, then free every slot
        send_round(MODE_FLOOD, BUFFERS + 2);
        for (int k = 0; k < BUFFERS; k++)
            send_word(OP_RELEASE, DEVICE_W'($urandom), $urandom, SLOT_W'(k));

        -> hold_rcvr;
        run_phase(15, 68, PHASE_WORDS);
        req_ch.valid = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        run_phase(68, 15, PHASE_WORDS);
        req_ch.valid = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        -> hold_rcvr;
        run_phase(0, 0, PHASE_WORDS);
        req_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d request words, checked %0d responses", words_sent, answered);
        $display("answers seen: %0d wait, %0d no buffer, %0d not busy; %0d mismatches",
                 waits, nobufs, notbusy, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bbct_pkg.sv
hw/rtl/bbct_ifs.sv
hw/rtl/bbct_ctrl.sv
hw/rtl/bbct_dpath.sv
hw/rtl/block_buffer_cache_tags_top.sv
dv/bbct_checker.sv
dv/testbench.sv
